// ===== sv/thumb_instruction_decoder_assert.svh =====
// assertion macros for the thumb decoder rtl
`ifndef THUMB_INSTRUCTION_DECODER_ASSERT_SVH
`define THUMB_INSTRUCTION_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TID_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tid_pkg.sv =====
// types and operation codes of the thumb instruction decoder
`default_nettype none

package tid_pkg;

   localparam logic [5:0] OP_BL    = 6'd0;
   localparam logic [5:0] OP_B     = 6'd1;
   localparam logic [5:0] OP_SWI   = 6'd2;
   localparam logic [5:0] OP_BCOND = 6'd3;
   localparam logic [5:0] OP_LDMIA = 6'd4;
   localparam logic [5:0] OP_STMIA = 6'd5;
   localparam logic [5:0] OP_POP   = 6'd6;
   localparam logic [5:0] OP_PUSH  = 6'd7;
   localparam logic [5:0] OP_SUB   = 6'd8;
   localparam logic [5:0] OP_ADD   = 6'd9;
   localparam logic [5:0] OP_ADR   = 6'd10;
   localparam logic [5:0] OP_LDR   = 6'd11;
   localparam logic [5:0] OP_STR   = 6'd12;
   localparam logic [5:0] OP_LDRH  = 6'd13;
   localparam logic [5:0] OP_STRH  = 6'd14;
   localparam logic [5:0] OP_AND   = 6'd15;
   localparam logic [5:0] OP_EOR   = 6'd16;
   localparam logic [5:0] OP_LSL   = 6'd17;
   localparam logic [5:0] OP_LSR   = 6'd18;
   localparam logic [5:0] OP_ASR   = 6'd19;
   localparam logic [5:0] OP_ADC   = 6'd20;
   localparam logic [5:0] OP_SBC   = 6'd21;
   localparam logic [5:0] OP_ROR   = 6'd22;
   localparam logic [5:0] OP_TST   = 6'd23;
   localparam logic [5:0] OP_NEG   = 6'd24;
   localparam logic [5:0] OP_CMP   = 6'd25;
   localparam logic [5:0] OP_CMN   = 6'd26;
   localparam logic [5:0] OP_ORR   = 6'd27;
   localparam logic [5:0] OP_MUL   = 6'd28;
   localparam logic [5:0] OP_BIC   = 6'd29;
   localparam logic [5:0] OP_MVN   = 6'd30;
   localparam logic [5:0] OP_MOV   = 6'd31;
   localparam logic [5:0] OP_BX    = 6'd32;
   localparam logic [5:0] OP_LDRB  = 6'd33;
   localparam logic [5:0] OP_STRB  = 6'd34;
   localparam logic [5:0] OP_LDSB  = 6'd35;
   localparam logic [5:0] OP_LDSH  = 6'd36;

   localparam logic [3:0]  REG_SP    = 4'd13;
   localparam logic [3:0]  REG_PC    = 4'd15;
   localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;

   typedef struct packed {
      logic [15:0] instr;
      logic [31:0] pc_value;
      logic [15:0] next_half;
   } tid_req_type;

   typedef struct packed {
      logic [5:0]  mnemonic;
      logic [3:0]  dest_reg;
      logic [3:0]  src_reg;
      logic [2:0]  third_reg;
      logic [9:0]  immediate;
      logic        imm_form;
      logic [3:0]  cond;
      logic [7:0]  reg_list;
      logic        extra_reg;
      logic [31:0] target;
   } tid_rsp_type;

   // how the target is built: base (pc+2, word aligned for literals) plus two offsets
   typedef struct packed {
      logic        has_tgt;
      logic        lit;
      logic [31:0] off_hi;
      logic [31:0] off_lo;
   } tid_tgt_type;

endpackage

`default_nettype wire

// ===== sv/tid_decode.sv =====
// field decode of one thumb halfword, target offsets left for the adders
`default_nettype none

module tid_decode (
   input  wire logic [15:0]         instr,
   input  wire logic [15:0]         next_half,
   output tid_pkg::tid_rsp_type     fields,
   output tid_pkg::tid_tgt_type     tgt
);

   logic [2:0] r0;
   logic [2:0] r3;
   logic [2:0] r6;
   logic [2:0] r8;
   logic [4:0] imm5;
   logic [7:0] imm8;

   assign r0   = instr[2:0];
   assign r3   = instr[5:3];
   assign r6   = instr[8:6];
   assign r8   = instr[10:8];
   assign imm5 = instr[10:6];
   assign imm8 = instr[7:0];

   always_comb begin
      fields = '0;
      tgt    = '0;
      unique case (instr[15:12]) inside
         4'hF: begin
            fields.mnemonic = tid_pkg::OP_BL;
            tgt.has_tgt     = 1'b1;
            tgt.off_hi      = {{9{instr[10]}}, instr[10:0], 12'b0};
            tgt.off_lo      = {20'b0, next_half[10:0], 1'b0};
         end
         4'hE: begin
            fields.mnemonic = tid_pkg::OP_B;
            tgt.has_tgt     = 1'b1;
            tgt.off_hi      = {{20{instr[10]}}, instr[10:0], 1'b0};
         end
         4'hD: begin
            if (instr[11:8] == 4'hF) begin
               fields.mnemonic  = tid_pkg::OP_SWI;
               fields.immediate = {2'b0, imm8};
               fields.imm_form  = 1'b1;
            end else begin
               fields.mnemonic = tid_pkg::OP_BCOND;
               fields.cond     = instr[11:8];
               tgt.has_tgt     = 1'b1;
               tgt.off_hi      = {{23{instr[7]}}, imm8, 1'b0};
            end
         end
         4'hC: begin
            fields.mnemonic = instr[11] ? tid_pkg::OP_LDMIA : tid_pkg::OP_STMIA;
            fields.dest_reg = {1'b0, r8};
            fields.reg_list = imm8;
         end
         4'hB: begin
            if (instr[10]) begin
               fields.mnemonic  = instr[11] ? tid_pkg::OP_POP : tid_pkg::OP_PUSH;
               fields.dest_reg  = tid_pkg::REG_SP;
               fields.reg_list  = imm8;
               fields.extra_reg = instr[8];
            end else begin
               fields.mnemonic  = instr[7] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
               fields.dest_reg  = tid_pkg::REG_SP;
               fields.src_reg   = tid_pkg::REG_SP;
               fields.immediate = {1'b0, instr[6:0], 2'b0};
               fields.imm_form  = 1'b1;
            end
         end
         4'hA: begin
            fields.mnemonic  = tid_pkg::OP_ADR;
            fields.dest_reg  = {1'b0, r8};
            fields.src_reg   = instr[11] ? tid_pkg::REG_SP : tid_pkg::REG_PC;
            fields.immediate = {imm8, 2'b0};
            fields.imm_form  = 1'b1;
         end
         4'h9: begin
            fields.mnemonic  = instr[11] ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
            fields.dest_reg  = {1'b0, r8};
            fields.src_reg   = tid_pkg::REG_SP;
            fields.immediate = {imm8, 2'b0};
            fields.imm_form  = 1'b1;
         end
         4'h8: begin
            fields.mnemonic  = instr[11] ? tid_pkg::OP_LDRH : tid_pkg::OP_STRH;
            fields.dest_reg  = {1'b0, r0};
            fields.src_reg   = {1'b0, r3};
            fields.immediate = {4'b0, imm5, 1'b0};
            fields.imm_form  = 1'b1;
         end
         4'h6, 4'h7: begin
            if (instr[12]) begin
               fields.mnemonic  = instr[11] ? tid_pkg::OP_LDRB : tid_pkg::OP_STRB;
               fields.immediate = {5'b0, imm5};
            end else begin
               fields.mnemonic  = instr[11] ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
               fields.immediate = {3'b0, imm5, 2'b0};
            end
            fields.dest_reg = {1'b0, r0};
            fields.src_reg  = {1'b0, r3};
            fields.imm_form = 1'b1;
         end
         4'h5: begin
            if (instr[9]) begin
               unique case (instr[11:10])
                  2'd0:    fields.mnemonic = tid_pkg::OP_STRH;
                  2'd1:    fields.mnemonic = tid_pkg::OP_LDSB;
                  2'd2:    fields.mnemonic = tid_pkg::OP_LDRH;
                  default: fields.mnemonic = tid_pkg::OP_LDSH;
               endcase
            end else if (instr[10]) begin
               fields.mnemonic = instr[11] ? tid_pkg::OP_LDRB : tid_pkg::OP_STRB;
            end else begin
               fields.mnemonic = instr[11] ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
            end
            fields.dest_reg  = {1'b0, r0};
            fields.src_reg   = {1'b0, r3};
            fields.third_reg = r6;
         end
         4'h4: begin
            if (instr[11]) begin
               // pc-relative literal load
               fields.mnemonic  = tid_pkg::OP_LDR;
               fields.dest_reg  = {1'b0, r8};
               fields.src_reg   = tid_pkg::REG_PC;
               fields.immediate = {imm8, 2'b0};
               fields.imm_form  = 1'b1;
               tgt.has_tgt      = 1'b1;
               tgt.lit          = 1'b1;
               tgt.off_lo       = {22'b0, imm8, 2'b0};
            end else if (instr[10]) begin
               // high register operations, bx leaves the destination clear
               fields.src_reg = instr[6:3];
               unique case (instr[9:8])
                  2'd0: begin
                     fields.mnemonic = tid_pkg::OP_ADD;
                     fields.dest_reg = {instr[7], r0};
                  end
                  2'd1: begin
                     fields.mnemonic = tid_pkg::OP_CMP;
                     fields.dest_reg = {instr[7], r0};
                  end
                  2'd2: begin
                     fields.mnemonic = tid_pkg::OP_MOV;
                     fields.dest_reg = {instr[7], r0};
                  end
                  default: fields.mnemonic = tid_pkg::OP_BX;
               endcase
            end else begin
               fields.dest_reg = {1'b0, r0};
               fields.src_reg  = {1'b0, r3};
               unique case (instr[9:6])
                  4'h0:    fields.mnemonic = tid_pkg::OP_AND;
                  4'h1:    fields.mnemonic = tid_pkg::OP_EOR;
                  4'h2:    fields.mnemonic = tid_pkg::OP_LSL;
                  4'h3:    fields.mnemonic = tid_pkg::OP_LSR;
                  4'h4:    fields.mnemonic = tid_pkg::OP_ASR;
                  4'h5:    fields.mnemonic = tid_pkg::OP_ADC;
                  4'h6:    fields.mnemonic = tid_pkg::OP_SBC;
                  4'h7:    fields.mnemonic = tid_pkg::OP_ROR;
                  4'h8:    fields.mnemonic = tid_pkg::OP_TST;
                  4'h9:    fields.mnemonic = tid_pkg::OP_NEG;
                  4'hA:    fields.mnemonic = tid_pkg::OP_CMP;
                  4'hB:    fields.mnemonic = tid_pkg::OP_CMN;
                  4'hC:    fields.mnemonic = tid_pkg::OP_ORR;
                  4'hD:    fields.mnemonic = tid_pkg::OP_MUL;
                  4'hE:    fields.mnemonic = tid_pkg::OP_BIC;
                  default: fields.mnemonic = tid_pkg::OP_MVN;
               endcase
            end
         end
         4'h2, 4'h3: begin
            fields.dest_reg  = {1'b0, r8};
            fields.immediate = {2'b0, imm8};
            fields.imm_form  = 1'b1;
            unique case (instr[12:11])
               2'd0: fields.mnemonic = tid_pkg::OP_MOV;
               2'd1: begin
                  fields.mnemonic = tid_pkg::OP_CMP;
                  fields.src_reg  = {1'b0, r8};
               end
               2'd2: begin
                  fields.mnemonic = tid_pkg::OP_ADD;
                  fields.src_reg  = {1'b0, r8};
               end
               default: begin
                  fields.mnemonic = tid_pkg::OP_SUB;
                  fields.src_reg  = {1'b0, r8};
               end
            endcase
         end
         default: begin
            // shifts by immediate, and three-operand add and subtract
            fields.dest_reg = {1'b0, r0};
            fields.src_reg  = {1'b0, r3};
            unique case (instr[12:11])
               2'd0: begin
                  fields.mnemonic  = tid_pkg::OP_LSL;
                  fields.immediate = {5'b0, imm5};
                  fields.imm_form  = 1'b1;
               end
               2'd1: begin
                  fields.mnemonic  = tid_pkg::OP_LSR;
                  fields.immediate = {5'b0, imm5};
                  fields.imm_form  = 1'b1;
               end
               2'd2: begin
                  fields.mnemonic  = tid_pkg::OP_ASR;
                  fields.immediate = {5'b0, imm5};
                  fields.imm_form  = 1'b1;
               end
               default: begin
                  fields.mnemonic = instr[9] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
                  if (instr[10]) begin
                     fields.immediate = {7'b0, r6};
                     fields.imm_form  = 1'b1;
                  end else begin
                     fields.third_reg = r6;
                  end
               end
            endcase
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/thumb_instruction_decoder.sv =====
// thumb instruction decoder: four-stage pipeline from halfword to decoded fields
//
// req_ carries one halfword, its pc (instruction address plus two) and the
// following halfword; rsp_ returns one decoded item for every request, in order.
// A transfer happens on a rising clock edge with valid high and stall low.
// A transferred request passes through an input register, field decode with
// pc+2, base plus high offset and base plus low offset into the output
// register, which drives rsp_valid. The two 32-bit adds of the target set the
// stage split. Throughput is one item per cycle while rsp_stall is low; every
// stage holds its own valid bit, so a new request is taken while older ones
// are still in flight.
// When rsp_stall is high the output register holds its item and the stages
// behind it keep filling any empty slots; req_stall rises only once every
// stage is occupied, so nothing is dropped or repeated.
// Synchronous reset empties the pipeline; no item is shown until new requests
// arrive. The block has no configuration and no state between items.
`default_nettype none

`include "thumb_instruction_decoder_assert.svh"

module thumb_instruction_decoder (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire tid_pkg::tid_req_type req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      tid_pkg::tid_rsp_type rsp_data
);

   // stage a: registered request
   logic                 a_vld_ff, a_vld_in;
   tid_pkg::tid_req_type a_req_ff, a_req_in;
   // stage b: decoded fields, pc+2 and target offsets
   logic                 b_vld_ff, b_vld_in;
   tid_pkg::tid_rsp_type b_fld_ff, b_fld_in;
   tid_pkg::tid_tgt_type b_tgt_ff, b_tgt_in;
   logic [31:0]          b_pc2_ff, b_pc2_in;
   // stage c: partial target sum
   logic                 c_vld_ff, c_vld_in;
   tid_pkg::tid_rsp_type c_fld_ff, c_fld_in;
   logic [31:0]          c_sum_ff, c_sum_in;
   logic [31:0]          c_off_ff, c_off_in;
   logic                 c_has_ff, c_has_in;
   // stage d: output register
   logic                 d_vld_ff, d_vld_in;
   tid_pkg::tid_rsp_type d_rsp_ff, d_rsp_in;

   logic a_rdy, b_rdy, c_rdy, d_rdy;
   tid_pkg::tid_rsp_type dec_fld;
   tid_pkg::tid_tgt_type dec_tgt;
   logic [31:0]          b_base;

   assign d_rdy = !d_vld_ff || !rsp_stall;
   assign c_rdy = !c_vld_ff || d_rdy;
   assign b_rdy = !b_vld_ff || c_rdy;
   assign a_rdy = !a_vld_ff || b_rdy;

   assign req_stall = !a_rdy;
   assign rsp_valid = d_vld_ff;
   assign rsp_data  = d_rsp_ff;

   tid_decode u_decode (
      .instr     (a_req_ff.instr),
      .next_half (a_req_ff.next_half),
      .fields    (dec_fld),
      .tgt       (dec_tgt)
   );

   // literal loads use the word-aligned pc, branches the plain pc+2
   assign b_base = b_tgt_ff.lit ? (b_pc2_ff & tid_pkg::WORD_MASK) : b_pc2_ff;

   always_comb begin
      a_vld_in = a_vld_ff;
      a_req_in = a_req_ff;
      if (a_rdy) begin
         a_vld_in = req_valid;
         a_req_in = req_data;
      end

      b_vld_in = b_vld_ff;
      b_fld_in = b_fld_ff;
      b_tgt_in = b_tgt_ff;
      b_pc2_in = b_pc2_ff;
      if (b_rdy) begin
         b_vld_in = a_vld_ff;
         b_fld_in = dec_fld;
         b_tgt_in = dec_tgt;
         b_pc2_in = a_req_ff.pc_value + 32'd2;
      end

      c_vld_in = c_vld_ff;
      c_fld_in = c_fld_ff;
      c_sum_in = c_sum_ff;
      c_off_in = c_off_ff;
      c_has_in = c_has_ff;
      if (c_rdy) begin
         c_vld_in = b_vld_ff;
         c_fld_in = b_fld_ff;
         c_sum_in = b_base + b_tgt_ff.off_hi;
         c_off_in = b_tgt_ff.off_lo;
         c_has_in = b_tgt_ff.has_tgt;
      end

      d_vld_in = d_vld_ff;
      d_rsp_in = d_rsp_ff;
      if (d_rdy) begin
         d_vld_in        = c_vld_ff;
         d_rsp_in        = c_fld_ff;
         d_rsp_in.target = c_has_ff ? (c_sum_ff + c_off_ff) : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff <= a_req_in;
      b_fld_ff <= b_fld_in;
      b_tgt_ff <= b_tgt_in;
      b_pc2_ff <= b_pc2_in;
      c_fld_ff <= c_fld_in;
      c_sum_ff <= c_sum_in;
      c_off_ff <= c_off_in;
      c_has_ff <= c_has_in;
      d_rsp_ff <= d_rsp_in;
   end

   // only branches and literal loads carry a target
   `TID_ASSERT_IMPLY(a_target_owner, clock, reset,
      rsp_valid && (rsp_data.target != 32'd0),
      (rsp_data.mnemonic == tid_pkg::OP_BL) || (rsp_data.mnemonic == tid_pkg::OP_B) ||
      (rsp_data.mnemonic == tid_pkg::OP_BCOND) || (rsp_data.mnemonic == tid_pkg::OP_LDR),
      "target set on an operation without one")

   // an immediate operand never comes with an offset register
   `TID_ASSERT_IMPLY(a_imm_no_reg, clock, reset,
      rsp_valid && rsp_data.imm_form, rsp_data.third_reg == 3'd0,
      "immediate form with an offset register")

   // with no stall downstream a transferred request reaches the output register
   `TID_ASSERT_NEXT(a_latency, clock, reset,
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall,
      rsp_valid, "request did not reach the output register in time")

endmodule

`default_nettype wire

// ===== tb/thumb_instruction_decoder_tb.sv =====
// self-checking testbench for the thumb instruction decoder: directed and random halfwords
`default_nettype none

module thumb_instruction_decoder_tb;

   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_ITEMS  = 550;
   localparam int PATTERN_COUNT = 61;
   localparam int STUCK_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 16;

   class decode_scoreboard;
      typedef struct {
         tid_pkg::tid_req_type req;
         tid_pkg::tid_rsp_type rsp;
      } pending_decode_type;

      pending_decode_type pending_q[$];
      int                 mismatches = 0;

      function logic [5:0] transfer_op(input logic byte_sel, input logic load);
         if (byte_sel) return load ? tid_pkg::OP_LDRB : tid_pkg::OP_STRB;
         return load ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
      endfunction

      function tid_pkg::tid_rsp_type decode_halfword(input tid_pkg::tid_req_type q);
         tid_pkg::tid_rsp_type r;
         logic [15:0] ins;
         logic [31:0] pc;
         logic [31:0] off;
         logic [3:0]  lo0, lo3, lo6, lo8;
         logic [4:0]  imm5;
         logic [7:0]  imm8;
         r    = '0;
         ins  = q.instr;
         pc   = q.pc_value;
         lo0  = {1'b0, ins[2:0]};
         lo3  = {1'b0, ins[5:3]};
         lo6  = {1'b0, ins[8:6]};
         lo8  = {1'b0, ins[10:8]};
         imm5 = ins[10:6];
         imm8 = ins[7:0];
         if (ins[15:12] == 4'hF) begin
            // either half of a bl pair is taken as the start, low offset from next_half
            off = {{9{ins[10]}}, ins[10:0], 12'b0};
            r.mnemonic = tid_pkg::OP_BL;
            r.target = pc + 32'd2 + off + {20'b0, q.next_half[10:0], 1'b0};
         end else if (ins[15:13] == 3'b111) begin
            off = {{20{ins[10]}}, ins[10:0], 1'b0};
            r.mnemonic = tid_pkg::OP_B;
            r.target = pc + 32'd2 + off;
         end else if (ins[15:12] == 4'hD) begin
            if (ins[11:8] == 4'hF) begin
               r.mnemonic  = tid_pkg::OP_SWI;
               r.immediate = {2'b0, imm8};
               r.imm_form  = 1'b1;
            end else begin
               off = {{23{ins[7]}}, imm8, 1'b0};
               r.mnemonic = tid_pkg::OP_BCOND;
               r.cond     = ins[11:8];
               r.target   = pc + 32'd2 + off;
            end
         end else if (ins[15:12] == 4'hC) begin
            r.mnemonic = ins[11] ? tid_pkg::OP_LDMIA : tid_pkg::OP_STMIA;
            r.dest_reg = lo8;
            r.reg_list = imm8;
         end else if (ins[15:12] == 4'hB) begin
            if (ins[10]) begin
               r.mnemonic  = ins[11] ? tid_pkg::OP_POP : tid_pkg::OP_PUSH;
               r.dest_reg  = tid_pkg::REG_SP;
               r.reg_list  = imm8;
               r.extra_reg = ins[8];
            end else begin
               r.mnemonic  = ins[7] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
               r.dest_reg  = tid_pkg::REG_SP;
               r.src_reg   = tid_pkg::REG_SP;
               r.immediate = {1'b0, ins[6:0], 2'b0};
               r.imm_form  = 1'b1;
            end
         end else if (ins[15:12] == 4'hA) begin
            r.mnemonic  = tid_pkg::OP_ADR;
            r.dest_reg  = lo8;
            r.src_reg   = ins[11] ? tid_pkg::REG_SP : tid_pkg::REG_PC;
            r.immediate = {imm8, 2'b0};
            r.imm_form  = 1'b1;
         end else if (ins[15:12] == 4'h9) begin
            r.mnemonic  = ins[11] ? tid_pkg::OP_LDR : tid_pkg::OP_STR;
            r.dest_reg  = lo8;
            r.src_reg   = tid_pkg::REG_SP;
            r.immediate = {imm8, 2'b0};
            r.imm_form  = 1'b1;
         end else if (ins[15:12] == 4'h8) begin
            r.mnemonic  = ins[11] ? tid_pkg::OP_LDRH : tid_pkg::OP_STRH;
            r.dest_reg  = lo0;
            r.src_reg   = lo3;
            r.immediate = {4'b0, imm5, 1'b0};
            r.imm_form  = 1'b1;
         end else if (ins[15:10] == 6'b010000) begin
            case (ins[9:6])
               4'd0:  r.mnemonic = tid_pkg::OP_AND;
               4'd1:  r.mnemonic = tid_pkg::OP_EOR;
               4'd2:  r.mnemonic = tid_pkg::OP_LSL;
               4'd3:  r.mnemonic = tid_pkg::OP_LSR;
               4'd4:  r.mnemonic = tid_pkg::OP_ASR;
               4'd5:  r.mnemonic = tid_pkg::OP_ADC;
               4'd6:  r.mnemonic = tid_pkg::OP_SBC;
               4'd7:  r.mnemonic = tid_pkg::OP_ROR;
               4'd8:  r.mnemonic = tid_pkg::OP_TST;
               4'd9:  r.mnemonic = tid_pkg::OP_NEG;
               4'd10: r.mnemonic = tid_pkg::OP_CMP;
               4'd11: r.mnemonic = tid_pkg::OP_CMN;
               4'd12: r.mnemonic = tid_pkg::OP_ORR;
               4'd13: r.mnemonic = tid_pkg::OP_MUL;
               4'd14: r.mnemonic = tid_pkg::OP_BIC;
               default: r.mnemonic = tid_pkg::OP_MVN;
            endcase
            r.dest_reg = lo0;
            r.src_reg  = lo3;
         end else if (ins[15:10] == 6'b010001) begin
            case (ins[9:8])
               2'd0:    r.mnemonic = tid_pkg::OP_ADD;
               2'd1:    r.mnemonic = tid_pkg::OP_CMP;
               2'd2:    r.mnemonic = tid_pkg::OP_MOV;
               default: r.mnemonic = tid_pkg::OP_BX;
            endcase
            r.src_reg = ins[6:3];
            if (r.mnemonic != tid_pkg::OP_BX) r.dest_reg = {ins[7], ins[2:0]};
         end else if (ins[15:11] == 5'b01001) begin
            r.mnemonic  = tid_pkg::OP_LDR;
            r.dest_reg  = lo8;
            r.src_reg   = tid_pkg::REG_PC;
            r.immediate = {imm8, 2'b0};
            r.imm_form  = 1'b1;
            r.target    = ((pc + 32'd2) & tid_pkg::WORD_MASK) + {22'b0, imm8, 2'b0};
         end else if (ins[15:13] == 3'b011) begin
            r.mnemonic  = transfer_op(ins[12], ins[11]);
            r.dest_reg  = lo0;
            r.src_reg   = lo3;
            r.immediate = ins[12] ? {5'b0, imm5} : {3'b0, imm5, 2'b0};
            r.imm_form  = 1'b1;
         end else if (ins[15:12] == 4'h5) begin
            if (ins[9]) begin
               case (ins[11:10])
                  2'd0:    r.mnemonic = tid_pkg::OP_STRH;
                  2'd1:    r.mnemonic = tid_pkg::OP_LDSB;
                  2'd2:    r.mnemonic = tid_pkg::OP_LDRH;
                  default: r.mnemonic = tid_pkg::OP_LDSH;
               endcase
            end else begin
               r.mnemonic = transfer_op(ins[10], ins[11]);
            end
            r.dest_reg  = lo0;
            r.src_reg   = lo3;
            r.third_reg = ins[8:6];
         end else if (ins[15:13] == 3'b001) begin
            case (ins[12:11])
               2'd0:    r.mnemonic = tid_pkg::OP_MOV;
               2'd1:    r.mnemonic = tid_pkg::OP_CMP;
               2'd2:    r.mnemonic = tid_pkg::OP_ADD;
               default: r.mnemonic = tid_pkg::OP_SUB;
            endcase
            r.dest_reg  = lo8;
            r.src_reg   = (r.mnemonic == tid_pkg::OP_MOV) ? 4'd0 : lo8;
            r.immediate = {2'b0, imm8};
            r.imm_form  = 1'b1;
         end else begin
            r.dest_reg = lo0;
            r.src_reg  = lo3;
            if (ins[12:11] != 2'd3) begin
               case (ins[12:11])
                  2'd0:    r.mnemonic = tid_pkg::OP_LSL;
                  2'd1:    r.mnemonic = tid_pkg::OP_LSR;
                  default: r.mnemonic = tid_pkg::OP_ASR;
               endcase
               r.immediate = {5'b0, imm5};
               r.imm_form  = 1'b1;
            end else begin
               r.mnemonic = ins[9] ? tid_pkg::OP_SUB : tid_pkg::OP_ADD;
               if (ins[10]) begin
                  r.immediate = {6'b0, lo6};
                  r.imm_form  = 1'b1;
               end else begin
                  r.third_reg = ins[8:6];
               end
            end
         end
         return r;
      endfunction

      function void note_request(input tid_pkg::tid_req_type q);
         pending_decode_type p;
         p.req = q;
         p.rsp = decode_halfword(q);
         pending_q.push_back(p);
      endfunction

      task report(input string what, input logic [15:0] ins,
                  input logic [31:0] got, input logic [31:0] want);
         $display("mismatch: %s instr %h got %0h expected %0h", what, ins, got, want);
         mismatches++;
      endtask

      task compare_field(input string what, input logic [15:0] ins,
                         input logic [31:0] got, input logic [31:0] want);
         if (got !== want) report(what, ins, got, want);
      endtask

      task check_result(input tid_pkg::tid_rsp_type got);
         pending_decode_type p;
         if (pending_q.size() == 0) begin
            report("result with nothing outstanding", 16'h0, got.target, 32'h0);
         end else begin
            p = pending_q.pop_front();
            compare_field("mnemonic",  p.req.instr, 32'(got.mnemonic),
                          32'(p.rsp.mnemonic));
            compare_field("dest_reg",  p.req.instr, 32'(got.dest_reg),
                          32'(p.rsp.dest_reg));
            compare_field("src_reg",   p.req.instr, 32'(got.src_reg),
                          32'(p.rsp.src_reg));
            compare_field("third_reg", p.req.instr, 32'(got.third_reg),
                          32'(p.rsp.third_reg));
            compare_field("immediate", p.req.instr, 32'(got.immediate),
                          32'(p.rsp.immediate));
            compare_field("imm_form",  p.req.instr, 32'(got.imm_form),
                          32'(p.rsp.imm_form));
            compare_field("cond",      p.req.instr, 32'(got.cond),
                          32'(p.rsp.cond));
            compare_field("reg_list",  p.req.instr, 32'(got.reg_list),
                          32'(p.rsp.reg_list));
            compare_field("extra_reg", p.req.instr, 32'(got.extra_reg),
                          32'(p.rsp.extra_reg));
            compare_field("target",    p.req.instr, got.target, p.rsp.target);
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   tid_pkg::tid_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   tid_pkg::tid_rsp_type rsp_data;

   int req_idle_pct = 7;
   int rsp_idle_pct = 86;
   int stuck_cycles = 0;

   decode_scoreboard board;

   thumb_instruction_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("thumb_instruction_decoder_tb: done, errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // {fixed-bit mask, fixed-bit value} for each operation group
   function automatic logic [31:0] opcode_pattern(input int idx);
      int i;
      i = idx;
      if (i < 16) return {16'hFFC0, 16'h4000 | (16'(i) << 6)};
      i -= 16;
      if (i < 4) return {16'hFF00, 16'h4400 | (16'(i) << 8)};
      i -= 4;
      if (i < 8) return {16'hFE00, 16'h5000 | (16'(i) << 9)};
      i -= 8;
      if (i < 4) return {16'hF800, 16'h6000 | (16'(i) << 11)};
      i -= 4;
      if (i < 4) return {16'hF800, 16'h2000 | (16'(i) << 11)};
      i -= 4;
      if (i < 3) return {16'hF800, 16'(i) << 11};
      i -= 3;
      if (i < 4) return {16'hFE00, 16'h1800 | (16'(i) << 9)};
      i -= 4;
      case (i)
         0:  return {16'hF800, 16'h4800};
         1:  return {16'hF800, 16'h8000};
         2:  return {16'hF800, 16'h8800};
         3:  return {16'hF800, 16'h9000};
         4:  return {16'hF800, 16'h9800};
         5:  return {16'hF800, 16'hA000};
         6:  return {16'hF800, 16'hA800};
         7:  return {16'hF400, 16'hB000};
         8:  return {16'hFC00, 16'hB400};
         9:  return {16'hFC00, 16'hBC00};
         10: return {16'hF800, 16'hC000};
         11: return {16'hF800, 16'hC800};
         12: return {16'hF000, 16'hD000};
         13: return {16'hFF00, 16'hDF00};
         14: return {16'hFF00, 16'hDE00};
         15: return {16'hF000, 16'hE000};
         16: return {16'hF800, 16'hF000};
         default: return {16'hF800, 16'hF800};
      endcase
   endfunction

   task automatic send_halfword(input logic [15:0] ins, input logic [31:0] pc,
                                input logic [15:0] nh);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{instr: ins, pc_value: pc, next_half: nh};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(req_data);
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] pattern;
      logic [31:0] pc;
      logic [15:0] ins;
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // extremes and corner encodings
      send_halfword(16'hF7FF, 32'hFFFF_FFFE, 16'hFFFF);
      send_halfword(16'hF3FF, 32'h0000_0000, 16'h0000);
      send_halfword(16'hF800, 32'h0000_1000, 16'h07FF);
      send_halfword(16'hE400, 32'h0000_0000, 16'h0000);
      send_halfword(16'hE3FF, 32'hFFFF_FFFC, 16'h0000);
      send_halfword(16'hEFFF, 32'h1234_5678, 16'hFFFF);
      send_halfword(16'hDE80, 32'h0000_0000, 16'h0000);
      send_halfword(16'hD07F, 32'hFFFF_FFFF, 16'h0000);
      send_halfword(16'hDF00, 32'h0000_0002, 16'h0000);
      send_halfword(16'hDFFF, 32'h0000_0002, 16'hFFFF);
      send_halfword(16'hCFFF, 32'h8000_0000, 16'h0000);
      send_halfword(16'hC000, 32'h8000_0000, 16'h0000);
      send_halfword(16'hB5FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'hBDFF, 32'h0000_0100, 16'h0000);
      send_halfword(16'hB600, 32'h0000_0100, 16'h0000);
      send_halfword(16'hB0FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'hB37F, 32'h0000_0100, 16'h0000);
      send_halfword(16'hA7FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'hAFFF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h9FFF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h4FFF, 32'hFFFF_FFFD, 16'h0000);
      send_halfword(16'h4800, 32'h0000_0001, 16'h0000);
      send_halfword(16'h47FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h46FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h5E3F, 32'h0000_0100, 16'h0000);
      send_halfword(16'h7FFF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h07FF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h1FFF, 32'h0000_0100, 16'h0000);
      send_halfword(16'h0000, 32'h0000_0000, 16'h0000);
      send_halfword(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);

      // hold off until the pipeline has fully emptied
      wait_for_results();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3) begin
            wait_for_results();
            req_idle_pct <= 86;
            rsp_idle_pct <= 7;
         end else if (k == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct <= 0;
            rsp_idle_pct <= 0;
         end
         // one pass over every operation group, then biased random
         if (k < PATTERN_COUNT)
            pattern = opcode_pattern(k);
         else if ($urandom_range(99) < 60)
            pattern = opcode_pattern($urandom_range(PATTERN_COUNT - 1));
         else
            pattern = '0;
         ins = (16'($urandom) & ~pattern[31:16]) | pattern[15:0];
         case ($urandom_range(9))
            0:       pc = 32'hFFFF_FFF0 | 32'($urandom_range(15));
            1:       pc = 32'($urandom_range(15));
            default: pc = $urandom;
         endcase
         send_halfword(ins, pc, 16'($urandom));
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("thumb_instruction_decoder_tb: done, clean");
      else
         $display("thumb_instruction_decoder_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
